/* sv/pqa_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pqa_pkg
// shared types, constants and saturating add for the piecewise quadratic argmin block
// ----------------------------------------------------------------------------
package pqa_pkg;

    localparam int FracBits = 16;
    localparam int DivBits  = 32 + FracBits + 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHOOSE,
        ST_EVAL_A,
        ST_EVAL_B,
        ST_EVAL_C,
        ST_EVAL_D,
        ST_NEXT,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        PT_VERTEX,
        PT_LEFT,
        PT_RIGHT
    } t_point;

    localparam logic [63:0] ValMax = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] ValMin = 64'h8000_0000_0000_0000;

    function automatic logic [63:0] sat_add(input logic [63:0] x, input logic [63:0] y);
        logic [64:0] s;
        s = {x[63], x} + {y[63], y};
        if (s[64] != s[63]) begin
            sat_add = s[64] ? ValMin : ValMax;
        end else begin
            sat_add = s[63:0];
        end
    endfunction

endpackage
`default_nettype wire

/* sv/piecewise_quadratic_argmin.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// piecewise_quadratic_argmin
// running argmin over a piecewise quadratic, one segment per item
// ----------------------------------------------------------------------------
// for a last segment with nonzero a, the divide runs, its done flag is
//   registered, then one vertex evaluation or up to two endpoint evaluations
//   follow before the result; with zero a the divide is skipped
// one segment at a time: the next item is taken only once the last one is
//   through, and not while a result waits
// reset: synchronous active low; clears control, best value and config
module piecewise_quadratic_argmin (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic signed [31:0] i_coef_square,
    input  wire logic signed [31:0] i_coef_linear,
    input  wire logic signed [31:0] i_coef_const,
    input  wire logic signed [31:0] i_right_boundary,
    input  wire logic        i_right_unbounded,
    input  wire logic        i_last_segment,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic signed [31:0] o_argmin_x,
    output logic             o_found_any
);
    localparam int F  = pqa_pkg::FracBits;
    localparam int DW = pqa_pkg::DivBits;

    // configuration
    logic        r_left_bounded;
    logic [31:0] r_left_boundary;

    // segment item
    logic [31:0] r_a, r_b, r_c, r_right;
    logic        r_right_unb, r_last;

    // running state
    logic [31:0] r_seg_left;
    logic        r_seg_left_unb;
    logic [63:0] r_best_val;
    logic [31:0] r_best_x;
    logic        r_any;
    logic        r_start;

    // work registers
    pqa_pkg::t_state r_state, n_state;
    pqa_pkg::t_point r_pt;
    logic        r_vert_used;
    logic [31:0] r_cx;          // clamped vertex
    logic [31:0] r_x;           // point under evaluation
    logic [63:0] r_m;           // |a|*|x| then |b|*|x|
    logic [63:0] r_t1;
    logic [95:0] r_p;           // partial product accumulator
    logic [63:0] r_y;

    // a finished evaluation waiting for its compare, with the x it belongs to
    logic        r_pt_pending;
    logic [31:0] r_x_prev;

    // shared 32x32 multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    logic [31:0] mag_a, mag_b, mag_x;
    assign mag_a = r_a[31] ? 32'(-r_a) : r_a;
    assign mag_b = r_b[31] ? 32'(-r_b) : r_b;
    assign mag_x = r_x[31] ? 32'(-r_x) : r_x;

    // magnitudes of the live item, loaded into the divider as it is taken
    logic [31:0] in_mag_a, in_mag_b;
    assign in_mag_a = i_coef_square[31] ? 32'(-i_coef_square) : i_coef_square;
    assign in_mag_b = i_coef_linear[31] ? 32'(-i_coef_linear) : i_coef_linear;

    // divider for the vertex
    logic          div_start, div_done;
    logic [DW-1:0] div_q;
    pqa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({{(DW-32){1'b0}}, in_mag_b} << F),
        .i_den   ({in_mag_a, 1'b0}),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // signed vertex in 64 bits for the range test
    logic        vneg;
    logic [63:0] vq, vcenter;
    logic        in_range;
    assign vneg    = (r_b != '0) && (r_b[31] == r_a[31]);
    assign vq      = 64'(div_q);
    assign vcenter = vneg ? 64'(-vq) : vq;
    assign in_range = (r_seg_left_unb ||
                       $signed({{32{r_seg_left[31]}}, r_seg_left}) <= $signed(vcenter)) &&
                      (r_right_unb ||
                       $signed(vcenter) <= $signed({{32{r_right[31]}}, r_right}));

    logic [31:0] clamp_c;
    always_comb begin
        if ($signed(vcenter) > $signed(64'sh7fff_ffff)) begin
            clamp_c = 32'h7fff_ffff;
        end else if ($signed(vcenter) < -$signed(64'sh8000_0000)) begin
            clamp_c = 32'h8000_0000;
        end else begin
            clamp_c = vcenter[31:0];
        end
    end

    // shift of the 96-bit a*x*x product by 2F, then saturate
    logic [95:0] sh2;
    logic [63:0] t1_val, t2_val, sh1;
    always_comb begin
        sh2 = r_p >> (2 * F);
        if (sh2[95:63] != '0) begin
            t1_val = r_a[31] ? pqa_pkg::ValMin : pqa_pkg::ValMax;
        end else begin
            t1_val = r_a[31] ? 64'(-sh2[63:0]) : sh2[63:0];
        end
        // sign of b*x taken from the x that was just evaluated
        sh1 = r_m >> F;
        t2_val = (r_b[31] != r_x_prev[31]) ? 64'(-sh1) : sh1;
    end

    // next point after the current one
    logic        has_next;
    pqa_pkg::t_point next_pt;
    always_comb begin
        has_next = 1'b0;
        next_pt  = pqa_pkg::PT_RIGHT;
        if (r_pt == pqa_pkg::PT_LEFT && !r_right_unb) begin
            has_next = 1'b1;
        end
    end

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        mul_a     = mag_a;
        mul_b     = mag_x;
        case (r_state)
            pqa_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = pqa_pkg::ST_DIV;
                end
            end
            pqa_pkg::ST_DIV: begin
                if (r_a == '0) begin
                    n_state = pqa_pkg::ST_CHOOSE;
                end else if (div_done) begin
                    n_state = pqa_pkg::ST_CHOOSE;
                end
            end
            pqa_pkg::ST_CHOOSE: begin
                n_state = pqa_pkg::ST_EVAL_A;
                if (!((r_vert_used)) && r_seg_left_unb && r_right_unb) begin
                    n_state = pqa_pkg::ST_NEXT;
                end
            end
            pqa_pkg::ST_EVAL_A: begin
                n_state = pqa_pkg::ST_EVAL_B;
            end
            pqa_pkg::ST_EVAL_B: begin
                // low half of |a||x| times |x|
                mul_a   = r_m[31:0];
                n_state = pqa_pkg::ST_EVAL_C;
            end
            pqa_pkg::ST_EVAL_C: begin
                mul_a   = r_m[63:32];
                n_state = pqa_pkg::ST_EVAL_D;
            end
            pqa_pkg::ST_EVAL_D: begin
                mul_a   = mag_b;
                n_state = (!r_vert_used && has_next) ? pqa_pkg::ST_EVAL_A : pqa_pkg::ST_NEXT;
            end
            pqa_pkg::ST_NEXT: begin
                n_state = r_last ? pqa_pkg::ST_OUT : pqa_pkg::ST_IDLE;
            end
            pqa_pkg::ST_OUT: begin
                if (i_ready) begin
                    n_state = pqa_pkg::ST_IDLE;
                end
            end
            default: n_state = pqa_pkg::ST_IDLE;
        endcase
        if (r_state == pqa_pkg::ST_IDLE && i_valid && i_coef_square != '0) begin
            div_start = 1'b1;
        end
    end

    // ready is high in idle; div start uses the live item in idle
    assign o_ready = (r_state == pqa_pkg::ST_IDLE);
    assign o_valid = (r_state == pqa_pkg::ST_OUT);
    assign o_argmin_x  = r_best_x;
    assign o_found_any = r_any;

    logic [63:0] y_new;
    assign y_new = pqa_pkg::sat_add(pqa_pkg::sat_add(r_t1, t2_val),
                                    {{32{r_c[31]}}, r_c});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= pqa_pkg::ST_IDLE;
            r_left_bounded  <= 1'b0;
            r_left_boundary <= '0;
            r_start         <= 1'b1;
            r_any           <= 1'b0;
            r_best_val      <= pqa_pkg::ValMax;
            r_best_x        <= '0;
            r_seg_left      <= '0;
            r_seg_left_unb  <= 1'b1;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == 1'b0) begin
                    r_left_bounded <= i_cfg_data[0];
                end else begin
                    r_left_boundary <= i_cfg_data;
                end
            end
            case (r_state)
                pqa_pkg::ST_IDLE: begin
                    if (i_valid) begin
                        r_a         <= i_coef_square;
                        r_b         <= i_coef_linear;
                        r_c         <= i_coef_const;
                        r_right     <= i_right_boundary;
                        r_right_unb <= i_right_unbounded;
                        r_last      <= i_last_segment;
                        if (r_start) begin
                            r_seg_left     <= r_left_boundary;
                            r_seg_left_unb <= !r_left_bounded;
                            r_start        <= 1'b0;
                        end
                    end
                end
                pqa_pkg::ST_DIV: begin
                    r_vert_used <= (r_a != '0) && div_done && in_range;
                    if (r_a != '0 && div_done) begin
                        r_cx <= clamp_c;
                    end
                end
                pqa_pkg::ST_CHOOSE: begin
                    if (r_vert_used) begin
                        r_pt <= pqa_pkg::PT_VERTEX;
                        r_x  <= r_cx;
                    end else if (!r_seg_left_unb) begin
                        r_pt <= pqa_pkg::PT_LEFT;
                        r_x  <= r_seg_left;
                    end else begin
                        r_pt <= pqa_pkg::PT_RIGHT;
                        r_x  <= r_right;
                    end
                end
                pqa_pkg::ST_EVAL_A: begin
                    r_m <= mul_p;
                end
                pqa_pkg::ST_EVAL_B: begin
                    r_p <= {32'd0, mul_p};
                end
                pqa_pkg::ST_EVAL_C: begin
                    r_p <= r_p + {mul_p, 32'd0};
                end
                pqa_pkg::ST_EVAL_D: begin
                    r_t1 <= t1_val;
                    r_m  <= mul_p;
                end
                default: ;
            endcase
            // compare lands in the state after the b*x product is registered
            if (r_state == pqa_pkg::ST_EVAL_A && r_pt_pending ||
                r_state == pqa_pkg::ST_NEXT && r_pt_pending) begin
                if (!r_any || $signed(y_new) < $signed(r_best_val)) begin
                    r_best_val <= y_new;
                    r_best_x   <= r_x_prev;
                    r_any      <= 1'b1;
                end
            end
            if (r_state == pqa_pkg::ST_EVAL_D && n_state == pqa_pkg::ST_EVAL_A) begin
                r_pt <= next_pt;
                r_x  <= r_right;
            end
            if (r_state == pqa_pkg::ST_NEXT) begin
                r_seg_left     <= r_right;
                r_seg_left_unb <= r_right_unb;
            end
            if (r_state == pqa_pkg::ST_OUT && i_ready) begin
                r_best_val <= pqa_pkg::ValMax;
                r_best_x   <= '0;
                r_any      <= 1'b0;
                r_start    <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pt_pending <= 1'b0;
        end else begin
            r_pt_pending <= (r_state == pqa_pkg::ST_EVAL_D);
        end
        if (r_state == pqa_pkg::ST_EVAL_D) begin
            r_x_prev <= r_x;
        end
    end

    // the result is only shown for a last segment
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == pqa_pkg::ST_NEXT) && r_last)
        else $error("result without last segment");
    // no item taken while a result waits
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("ready during result");
    // no candidate means the reported x is zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found_any) |-> (o_argmin_x == '0))
        else $error("nonzero x without candidate");

endmodule
`default_nettype wire

/* sv/pqa_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pqa_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pqa_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [pqa_pkg::DivBits-1:0] i_num,
    input  wire logic [32:0]                 i_den,
    output logic                             o_done,
    output logic [pqa_pkg::DivBits-1:0]      o_quot
);
    localparam int CntW = $clog2(pqa_pkg::DivBits + 1);

    logic [pqa_pkg::DivBits-1:0] r_quot;
    logic [33:0]                 r_rem;
    logic [32:0]                 r_den;
    logic [CntW-1:0]             r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [33:0]                 trial;

    // shift in the next numerator bit and try a subtract
    assign trial = {r_rem[32:0], r_quot[pqa_pkg::DivBits-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CntW'(pqa_pkg::DivBits);
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
            r_done <= 1'b0;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_den}) begin
                r_rem  <= trial - {1'b0, r_den};
                r_quot <= {r_quot[pqa_pkg::DivBits-2:0], 1'b1};
            end else begin
                r_rem  <= trial;
                r_quot <= {r_quot[pqa_pkg::DivBits-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CntW'(1)) begin
                r_busy <= 1'b0;
            end
            // done flag rises once the last quotient bit is in
            r_done <= (r_cnt == CntW'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule
`default_nettype wire
